// File: hdl/jmsp_pkg.sv
`default_nettype none
package jmsp_pkg;

    typedef enum logic [3:0] {
        PH_SOI_HI = 4'd0,
        PH_SOI_LO = 4'd1,
        PH_HUNT   = 4'd2,
        PH_TYPE   = 4'd3,
        PH_LEN_HI = 4'd4,
        PH_LEN_LO = 4'd5,
        PH_PREC   = 4'd6,
        PH_H_HI   = 4'd7,
        PH_H_LO   = 4'd8,
        PH_W_HI   = 4'd9,
        PH_W_LO   = 4'd10,
        PH_COMP   = 4'd11,
        PH_SKIP   = 4'd12,
        PH_STOP   = 4'd13
    } phase_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_SOI_OK = 3'd1,
        EV_NO_SOI = 3'd2,
        EV_MARKER = 3'd3,
        EV_FRAME  = 3'd4,
        EV_SCAN   = 3'd5,
        EV_END    = 3'd6,
        EV_SHORT  = 3'd7
    } event_t;

    localparam logic [15:0] SOI_WORD    = 16'hFFD8;
    localparam logic [7:0]  MARK_PREFIX = 8'hFF;
    localparam logic [7:0]  MARK_SOI    = 8'hD8;
    localparam logic [7:0]  MARK_EOI    = 8'hD9;
    localparam logic [7:0]  MARK_SOF0   = 8'hC0;
    localparam logic [7:0]  MARK_SOS    = 8'hDA;
    localparam logic [7:0]  MARK_RST_LO = 8'hD0;
    localparam logic [7:0]  MARK_RST_HI = 8'hD7;
    localparam logic [15:0] MIN_LEN     = 16'd2;
    localparam logic [15:0] MIN_LEN_SOF = 16'd8;

    localparam int TDATA_OUT_W = 80;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  saved_marker;
        logic [7:0]  length_high;
        logic [15:0] bytes_left;
        logic [15:0] frame_height;
        logic [15:0] frame_width;
        logic [7:0]  frame_components;
        logic [7:0]  frame_precision;
        logic [15:0] seg_len;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:            PH_SOI_HI,
        saved_marker:     8'd0,
        length_high:      8'd0,
        bytes_left:       16'd0,
        frame_height:     16'd0,
        frame_width:      16'd0,
        frame_components: 8'd0,
        frame_precision:  8'd0,
        seg_len:          16'd0
    };

endpackage
`default_nettype wire

// File: hdl/jmsp_step.sv
`default_nettype none
module jmsp_step (
    input  wire jmsp_pkg::parse_state_t cur,
    input  wire logic [7:0]             data_byte,
    input  wire logic                   restart,
    output jmsp_pkg::parse_state_t      nxt,
    output jmsp_pkg::event_t            ev
);
    import jmsp_pkg::*;

    parse_state_t base;
    logic [15:0]  len;
    logic [15:0]  need;
    logic [15:0]  left_dec;
    logic         is_sof0;

    always_comb
    begin
        base     = restart ? STATE_RESET : cur;
        len      = {base.length_high, data_byte};
        is_sof0  = (base.saved_marker == MARK_SOF0);
        need     = is_sof0 ? MIN_LEN_SOF : MIN_LEN;
        left_dec = (base.bytes_left != 16'd0) ? base.bytes_left - 16'd1 : base.bytes_left;
        nxt      = base;
        ev       = EV_NONE;
        unique case (base.phase)
            PH_SOI_HI:
            begin
                nxt.length_high = data_byte;
                nxt.phase       = PH_SOI_LO;
            end
            PH_SOI_LO:
            begin
                if (len == SOI_WORD)
                begin
                    ev        = EV_SOI_OK;
                    nxt.phase = PH_HUNT;
                end
                else
                begin
                    ev        = EV_NO_SOI;
                    nxt.phase = PH_STOP;
                end
            end
            PH_HUNT:
            begin
                if (data_byte == MARK_PREFIX)
                    nxt.phase = PH_TYPE;
            end
            PH_TYPE:
            begin
                if (data_byte != MARK_PREFIX)
                begin
                    nxt.saved_marker = data_byte;
                    priority if (data_byte == MARK_SOI ||
                                 (data_byte >= MARK_RST_LO && data_byte <= MARK_RST_HI))
                        nxt.phase = PH_HUNT;
                    else if (data_byte == MARK_EOI)
                    begin
                        ev        = EV_END;
                        nxt.phase = PH_STOP;
                    end
                    else
                    begin
                        ev        = EV_MARKER;
                        nxt.phase = PH_LEN_HI;
                    end
                end
            end
            PH_LEN_HI:
            begin
                nxt.length_high = data_byte;
                nxt.phase       = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                nxt.seg_len = len;
                priority if (len < need)
                begin
                    ev        = EV_SHORT;
                    nxt.phase = PH_STOP;
                end
                else if (base.saved_marker == MARK_SOS)
                begin
                    ev        = EV_SCAN;
                    nxt.phase = PH_STOP;
                end
                else
                begin
                    nxt.bytes_left = len - MIN_LEN;
                    priority if (is_sof0)
                        nxt.phase = PH_PREC;
                    else if (len == MIN_LEN)
                        nxt.phase = PH_HUNT;
                    else
                        nxt.phase = PH_SKIP;
                end
            end
            PH_PREC:
            begin
                nxt.frame_precision = data_byte;
                nxt.bytes_left      = left_dec;
                nxt.phase           = PH_H_HI;
            end
            PH_H_HI:
            begin
                nxt.frame_height[15:8] = data_byte;
                nxt.bytes_left         = left_dec;
                nxt.phase              = PH_H_LO;
            end
            PH_H_LO:
            begin
                nxt.frame_height[7:0] = data_byte;
                nxt.bytes_left        = left_dec;
                nxt.phase             = PH_W_HI;
            end
            PH_W_HI:
            begin
                nxt.frame_width[15:8] = data_byte;
                nxt.bytes_left        = left_dec;
                nxt.phase             = PH_W_LO;
            end
            PH_W_LO:
            begin
                nxt.frame_width[7:0] = data_byte;
                nxt.bytes_left       = left_dec;
                nxt.phase            = PH_COMP;
            end
            PH_COMP:
            begin
                nxt.frame_components = data_byte;
                nxt.bytes_left       = left_dec;
                ev                   = EV_FRAME;
                nxt.phase            = (left_dec == 16'd0) ? PH_HUNT : PH_SKIP;
            end
            PH_SKIP:
            begin
                nxt.bytes_left = left_dec;
                if (left_dec == 16'd0)
                    nxt.phase = PH_HUNT;
            end
            PH_STOP:
            begin
                nxt.phase = PH_STOP;
            end
            default:
            begin
                nxt.phase = PH_STOP;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: hdl/jpeg_marker_segment_parser_core.sv
`default_nettype none
// Channel  Dir  tdata (low bit up)                               tuser
// s_*      in   [7:0] data_byte                                  [0] restart
// m_*      out  [7:0] marker_code, [23:8] segment_length,        [2:0] event_res
//               [39:24] image_height, [55:40] image_width,
//               [63:56] component_count, [71:64] sample_precision,
//               [72] stopped, [79:73] zero
// One result beat per input beat; a beat is accepted every cycle while the
// result register is free or being drained, so throughput is one byte per clock.
// The result is registered: the parser state and result register load on the same edge.
// rst_n clears the parser state and the result valid flag asynchronously.
// A stall on m_tready holds the result and drops s_tready until it is taken.
module jpeg_marker_segment_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] restart
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [jmsp_pkg::TDATA_OUT_W-1:0] m_tdata,  // see table above
    output logic [2:0]       m_tuser    // [2:0] event_res
);
    import jmsp_pkg::*;

    parse_state_t state_reg;
    parse_state_t state_next;
    event_t       ev_next;
    logic         valid_reg;
    logic [TDATA_OUT_W-1:0] data_reg;
    event_t       ev_reg;
    logic         s_accept;
    logic         stop_next;

    jmsp_step u_step (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .restart   (s_tuser),
        .nxt       (state_next),
        .ev        (ev_next)
    );

    assign s_tready  = !valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign stop_next = (state_next.phase == PH_STOP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (s_accept)
            begin
                state_reg <= state_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ev_reg   <= ev_next;
            data_reg <= {7'd0, stop_next,
                         state_next.frame_precision, state_next.frame_components,
                         state_next.frame_width, state_next.frame_height,
                         state_next.seg_len, state_next.saved_marker};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = ev_reg;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> m_tvalid)
        else $error("accepted beat produced no result");

    a_end_events_stop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_NO_SOI || m_tuser == EV_END ||
                      m_tuser == EV_SCAN || m_tuser == EV_SHORT)) |-> m_tdata[72])
        else $error("terminal event without stopped flag");

    a_live_events_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == EV_SOI_OK || m_tuser == EV_MARKER ||
                      m_tuser == EV_FRAME)) |-> !m_tdata[72])
        else $error("progress event with stopped flag set");

    a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && state_reg.phase == PH_STOP && !s_tuser) |=> state_reg.phase == PH_STOP)
        else $error("parser left stop without restart");

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import jmsp_pkg::*;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  marker;
        logic [15:0] seglen;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  comps;
        logic [7:0]  prec;
        logic        stopped;
    } parse_result_t;

    class parse_tracker;
        phase_t        ph;
        logic [7:0]    marker;
        logic [7:0]    len_hi;
        logic [15:0]   left;
        logic [15:0]   seglen;
        logic [15:0]   height;
        logic [15:0]   width;
        logic [7:0]    comps;
        logic [7:0]    prec;
        parse_result_t expected_results[$];
        int            errors;
        int            event_hits[8];

        function new();
            clear_state();
            errors = 0;
            foreach (event_hits[i]) event_hits[i] = 0;
        endfunction

        function void clear_state();
            ph     = PH_SOI_HI;
            marker = 8'd0;
            len_hi = 8'd0;
            left   = 16'd0;
            seglen = 16'd0;
            height = 16'd0;
            width  = 16'd0;
            comps  = 8'd0;
            prec   = 8'd0;
        endfunction

        function void take_byte(logic [7:0] d, logic r);
            parse_result_t res;
            logic [15:0]   len;
            logic [15:0]   need;
            event_t        ev;
            ev = EV_NONE;
            if (r)
                clear_state();
            case (ph)
                PH_SOI_HI:
                begin
                    len_hi = d;
                    ph = PH_SOI_LO;
                end
                PH_SOI_LO:
                begin
                    if ({len_hi, d} == SOI_WORD)
                    begin
                        ev = EV_SOI_OK;
                        ph = PH_HUNT;
                    end
                    else
                    begin
                        ev = EV_NO_SOI;
                        ph = PH_STOP;
                    end
                end
                PH_HUNT:
                begin
                    if (d == MARK_PREFIX)
                        ph = PH_TYPE;
                end
                PH_TYPE:
                begin
                    if (d != MARK_PREFIX)
                    begin
                        marker = d;
                        if (d == MARK_SOI || (d >= MARK_RST_LO && d <= MARK_RST_HI))
                            ph = PH_HUNT;
                        else if (d == MARK_EOI)
                        begin
                            ev = EV_END;
                            ph = PH_STOP;
                        end
                        else
                        begin
                            ev = EV_MARKER;
                            ph = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    len_hi = d;
                    ph = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len = {len_hi, d};
                    need = (marker == MARK_SOF0) ? MIN_LEN_SOF : MIN_LEN;
                    seglen = len;
                    if (len < need)
                    begin
                        ev = EV_SHORT;
                        ph = PH_STOP;
                    end
                    else if (marker == MARK_SOS)
                    begin
                        ev = EV_SCAN;
                        ph = PH_STOP;
                    end
                    else
                    begin
                        left = len - 16'd2;
                        if (marker == MARK_SOF0)
                            ph = PH_PREC;
                        else
                            ph = (left == 16'd0) ? PH_HUNT : PH_SKIP;
                    end
                end
                PH_PREC:
                begin
                    prec = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ph = PH_H_HI;
                end
                PH_H_HI:
                begin
                    height[15:8] = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ph = PH_H_LO;
                end
                PH_H_LO:
                begin
                    height[7:0] = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ph = PH_W_HI;
                end
                PH_W_HI:
                begin
                    width[15:8] = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ph = PH_W_LO;
                end
                PH_W_LO:
                begin
                    width[7:0] = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ph = PH_COMP;
                end
                PH_COMP:
                begin
                    comps = d;
                    if (left != 16'd0) left = left - 16'd1;
                    ev = EV_FRAME;
                    ph = (left == 16'd0) ? PH_HUNT : PH_SKIP;
                end
                PH_SKIP:
                begin
                    if (left != 16'd0) left = left - 16'd1;
                    if (left == 16'd0)
                        ph = PH_HUNT;
                end
                default:
                    ph = PH_STOP;
            endcase
            res.ev      = ev;
            res.marker  = marker;
            res.seglen  = seglen;
            res.height  = height;
            res.width   = width;
            res.comps   = comps;
            res.prec    = prec;
            res.stopped = (ph == PH_STOP);
            expected_results.push_back(res);
            event_hits[int'(ev)]++;
        endfunction

        function void check_field(string name, logic [15:0] expv, logic [15:0] actv);
            if (expv !== actv)
            begin
                $error("%s: expected %0h, got %0h", name, expv, actv);
                errors++;
            end
        endfunction

        function void match_result(logic [TDATA_OUT_W-1:0] td, logic [2:0] tu);
            parse_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("result beat with no byte outstanding");
                errors++;
                return;
            end
            e = expected_results.pop_front();
            check_field("event_res", 16'(e.ev), 16'(tu));
            check_field("marker_code", 16'(e.marker), 16'(td[7:0]));
            check_field("segment_length", e.seglen, td[23:8]);
            check_field("image_height", e.height, td[39:24]);
            check_field("image_width", e.width, td[55:40]);
            check_field("component_count", 16'(e.comps), 16'(td[63:56]));
            check_field("sample_precision", 16'(e.prec), 16'(td[71:64]));
            check_field("stopped", 16'(e.stopped), 16'(td[72]));
            check_field("tdata_pad", 16'd0, 16'(td[79:73]));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    wire logic              s_tready;
    logic [7:0]             s_tdata = 8'd0;
    logic                   s_tuser = 1'b0;
    wire logic              m_tvalid;
    logic                   m_tready = 1'b0;
    wire logic [TDATA_OUT_W-1:0] m_tdata;
    wire logic [2:0]        m_tuser;

    parse_tracker tracker = new();
    logic [7:0]   file_bytes[$];
    bit           steady = 1'b0;
    int           stall_left = 0;
    int           idle_cycles = 0;
    int           beats_sent = 0;
    int           files_sent = 0;

    jpeg_marker_segment_parser_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(2);
        else if (r < 95)
            return $urandom_range(8, 3);
        else
            return $urandom_range(60, 20);
    endfunction

    always @(negedge clk)
    begin
        if (stall_left == 0 && !steady && $urandom_range(3) == 0)
            stall_left = pick_gap();
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.match_result(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= 3000)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_beat(logic [7:0] d, logic r);
        int gap;
        gap = (steady || $urandom_range(2) != 0) ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= r;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_byte(d, r);
        beats_sent++;
    endtask

    task automatic send_file(bit first_restart);
        foreach (file_bytes[i])
            send_beat(file_bytes[i], (i == 0) ? first_restart : 1'b0);
        files_sent++;
    endtask

    function automatic logic [7:0] plain_marker();
        logic [7:0] m;
        do
            m = 8'($urandom_range(255));
        while (m == MARK_PREFIX || m == MARK_SOF0 || (m >= MARK_RST_LO && m <= MARK_SOS));
        return m;
    endfunction

    task automatic build_file();
        int         nseg;
        int         kind;
        int         len;
        int         r;
        logic [7:0] m;
        file_bytes.delete();
        if ($urandom_range(19) == 0)
        begin
            file_bytes.push_back(8'($urandom_range(255)));
            file_bytes.push_back(8'($urandom_range(255)));
        end
        else
        begin
            file_bytes.push_back(SOI_WORD[15:8]);
            file_bytes.push_back(SOI_WORD[7:0]);
        end
        nseg = $urandom_range(5);
        for (int s = 0; s < nseg; s++)
        begin
            if ($urandom_range(4) == 0)
                repeat ($urandom_range(3, 1)) file_bytes.push_back(8'($urandom_range(254)));
            file_bytes.push_back(MARK_PREFIX);
            if ($urandom_range(5) == 0)
                repeat ($urandom_range(3, 1)) file_bytes.push_back(MARK_PREFIX);
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                m = ($urandom_range(8) == 8) ? MARK_SOI : MARK_RST_LO + 8'($urandom_range(7));
                file_bytes.push_back(m);
            end
            else if (kind < 5)
            begin
                len = ($urandom_range(3) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 8);
                file_bytes.push_back(MARK_SOF0);
                file_bytes.push_back(len[15:8]);
                file_bytes.push_back(len[7:0]);
                repeat (len - 2) file_bytes.push_back(8'($urandom_range(255)));
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 85)
                    len = $urandom_range(24, 2);
                else if (r < 97)
                    len = $urandom_range(80, 25);
                else
                    len = $urandom_range(300, 256);
                file_bytes.push_back(plain_marker());
                file_bytes.push_back(len[15:8]);
                file_bytes.push_back(len[7:0]);
                repeat (len - 2) file_bytes.push_back(8'($urandom_range(255)));
            end
        end
        kind = $urandom_range(9);
        if (kind < 3)
        begin
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_EOI);
        end
        else if (kind < 5)
        begin
            r = $urandom_range(7);
            len = (r == 0) ? 16'hFFFF : (r == 1) ? $urandom_range(1) : $urandom_range(40, 2);
            file_bytes.push_back(MARK_PREFIX);
            file_bytes.push_back(MARK_SOS);
            file_bytes.push_back(len[15:8]);
            file_bytes.push_back(len[7:0]);
        end
        else if (kind < 7)
        begin
            file_bytes.push_back(MARK_PREFIX);
            if ($urandom_range(1) == 0)
            begin
                file_bytes.push_back(MARK_SOF0);
                len = $urandom_range(7);
            end
            else
            begin
                file_bytes.push_back(plain_marker());
                len = $urandom_range(1);
            end
            file_bytes.push_back(len[15:8]);
            file_bytes.push_back(len[7:0]);
        end
        else if (kind < 9)
        begin
            len = $urandom_range(file_bytes.size(), 1);
            while (file_bytes.size() > len)
                void'(file_bytes.pop_back());
        end
        repeat ($urandom_range(4)) file_bytes.push_back(8'($urandom_range(255)));
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // first file taken straight out of reset, no restart flag
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hFF, 8'hD0, 8'hFF, 8'hC0, 8'h00, 8'h08,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hD7,
                       8'hFF, 8'hE1, 8'h00, 8'h02, 8'hFF, 8'hD9, 8'h00};
        send_file(1'b0);
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hC0, 8'h00, 8'h07};
        send_file(1'b1);
        file_bytes = '{8'h00, 8'h00, 8'h5A};
        send_file(1'b1);
        file_bytes = '{8'hFF, 8'hD8, 8'hFF, 8'hDA, 8'hFF, 8'hFF};
        send_file(1'b1);

        while (beats_sent < 1680)
        begin
            steady = ($urandom_range(5) == 0);
            build_file();
            // on one file in fifteen, drain everything before this file
            if (files_sent % 15 == 7)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (tracker.expected_results.size() != 0) @(posedge clk);
            end
            send_file($urandom_range(19) != 0);
        end
        @(negedge clk);
        s_tvalid <= 1'b0;
        steady = 1'b0;

        while (tracker.expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d files in %0d beats: %0d soi, %0d bad soi, %0d markers",
                 files_sent, beats_sent, tracker.event_hits[EV_SOI_OK],
                 tracker.event_hits[EV_NO_SOI], tracker.event_hits[EV_MARKER]);
        $display("  %0d frame headers, %0d scan starts, %0d image ends, %0d short segments",
                 tracker.event_hits[EV_FRAME], tracker.event_hits[EV_SCAN],
                 tracker.event_hits[EV_END], tracker.event_hits[EV_SHORT]);
        if (tracker.errors == 0 && tracker.expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire

// File: jpeg_marker_segment_parser_core.f
hdl/jmsp_pkg.sv
hdl/jmsp_step.sv
hdl/jpeg_marker_segment_parser_core.sv
tb/testbench.sv
